// ===== hdl/apsd_pkg.sv =====
// package for the averaged peak-bin symbol demodulator
// types, register indexes and state codes shared by the apsd modules other than apsd_div
`timescale 1ns / 1ps
`default_nettype none

package apsd_pkg;

  // widest bin and row fields a job can carry (up to 8192 bins, 64 rows)
  localparam int BIN_MAX_W = 13;
  localparam int ROW_MAX_W = 6;

  typedef enum logic [1:0] {
    CFG_MODE = 2'd0,
    CFG_BINS = 2'd1,
    CFG_AVG  = 2'd2
  } apsd_cfg_e;

  typedef struct packed {
    logic        [15:0] power;
    logic signed [15:0] frequency;
  } apsd_in_t;

  typedef struct packed {
    logic signed [15:0] amplitude;
    logic signed [15:0] freq_reference;
  } apsd_out_t;

  // one classified bin on its way from the front to the back
  typedef struct packed {
    logic [15:0]          power;
    logic [15:0]          freq;
    logic [BIN_MAX_W-1:0] bin;
    logic [ROW_MAX_W-1:0] row;
    logic                 last;
  } apsd_job_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READP,
    ST_REF,
    ST_DIVREF,
    ST_AMP,
    ST_DIVAMP,
    ST_SQRT,
    ST_FINISH
  } apsd_state_e;

endpackage

`default_nettype wire

// ===== hdl/averaged_peak_bin_symbol_demod.sv =====
// Averaged peak-bin symbol demodulator. Each accepted bin is written to a
// store of MAX_AVG rows by MAX_BINS bins (rows and bins rounded
// up to powers of two). On the last bin of a symbol the back end sweeps the
// store one entry per cycle through its single read port, then runs a
// bit-serial division for the reference (only when mode is set) and, unless
// the peak sum is zero, one for the amplitude followed by a bit-serial square
// root; bins keep arriving into a two-entry queue meanwhile. After reset the
// whole store is zeroed, during which full stays high. Configuration writes
// are always accepted.
`timescale 1ns / 1ps
`default_nettype none

module averaged_peak_bin_symbol_demod import apsd_pkg::*; #(
  parameter int MAX_BINS = 1024,
  parameter int MAX_AVG  = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output      logic        full,
  input  wire apsd_in_t    in_data_i,
  output      logic        empty,
  input  wire logic        pop,
  output      apsd_out_t   out_data_o,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [10:0] cfg_data_i
);

  localparam int NB_W = $clog2(MAX_BINS + 1);
  localparam int NA_W = $clog2(MAX_AVG + 1);

  logic            mode_q;
  logic [10:0]     bins_q;
  logic [4:0]      avg_q;
  logic [NB_W-1:0] nb;
  logic [NA_W-1:0] na;

  logic      q_push, q_full, q_pop, q_empty, clearing;
  apsd_job_t q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (bins_q == 11'd0) begin
      nb = NB_W'(1);
    end else if (32'(bins_q) > MAX_BINS) begin
      nb = NB_W'(MAX_BINS);
    end else begin
      nb = NB_W'(bins_q);
    end
    if (avg_q == 5'd0) begin
      na = NA_W'(1);
    end else if (32'(avg_q) > MAX_AVG) begin
      na = NA_W'(MAX_AVG);
    end else begin
      na = NA_W'(avg_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      bins_q <= 11'd1024;
      avg_q  <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MODE: mode_q <= cfg_data_i[0];
        CFG_BINS: bins_q <= cfg_data_i;
        CFG_AVG:  avg_q  <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  apsd_front #(
    .MAX_BINS(MAX_BINS),
    .MAX_AVG (MAX_AVG)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .full_o    (full),
    .in_data_i (in_data_i),
    .nb_i      (nb),
    .na_i      (na),
    .q_full_i  (q_full),
    .clearing_i(clearing),
    .q_push_o  (q_push),
    .q_data_o  (q_in)
  );

  apsd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_out),
    .empty_o(q_empty)
  );

  apsd_back #(
    .MAX_BINS(MAX_BINS),
    .MAX_AVG (MAX_AVG)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .nb_i      (nb),
    .na_i      (na),
    .mode_i    (mode_q),
    .q_empty_i (q_empty),
    .q_data_i  (q_out),
    .q_pop_o   (q_pop),
    .clearing_o(clearing),
    .pop_i     (pop),
    .empty_o   (empty),
    .out_data_o(out_data_o)
  );

  // no bin may enter and no result may appear while the store is being zeroed
  a_clear_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("input accepted during store clear");

  a_clear_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> empty)
    else $error("result present during store clear");

  // the queue only drains into the back end when it holds a job
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("job queue popped while empty");

endmodule

`default_nettype wire

// ===== hdl/apsd_front.sv =====
// front end: accepts bins, tracks bin and row position, marks the end of a symbol
// depends on apsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module apsd_front import apsd_pkg::*; #(
  parameter int MAX_BINS = 1024,
  parameter int MAX_AVG  = 16,
  localparam int BIN_W = $clog2(MAX_BINS),
  localparam int ROW_W = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1,
  localparam int NB_W  = $clog2(MAX_BINS + 1),
  localparam int NA_W  = $clog2(MAX_AVG + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  output      logic            full_o,
  input  wire apsd_in_t        in_data_i,
  input  wire logic [NB_W-1:0] nb_i,
  input  wire logic [NA_W-1:0] na_i,
  input  wire logic            q_full_i,
  input  wire logic            clearing_i,
  output      logic            q_push_o,
  output      apsd_job_t       q_data_o
);

  logic [BIN_W-1:0] bin_q, bin_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             bin_last, row_last;

  assign full_o   = q_full_i | clearing_i;
  assign q_push_o = push_i & ~full_o;

  assign bin_last = (32'(bin_q) + 32'd1) >= 32'(nb_i);
  assign row_last = (32'(row_q) + 32'd1) >= 32'(na_i);

  always_comb begin
    q_data_o.power = in_data_i.power;
    q_data_o.freq  = in_data_i.frequency;
    q_data_o.bin   = BIN_MAX_W'(bin_q);
    q_data_o.row   = ROW_MAX_W'(row_q);
    q_data_o.last  = bin_last;
    bin_d = bin_q;
    row_d = row_q;
    if (q_push_o) begin
      if (bin_last) begin
        bin_d = '0;
        row_d = row_last ? '0 : row_q + ROW_W'(1);
      end else begin
        bin_d = bin_q + BIN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q <= '0;
      row_q <= '0;
    end else begin
      bin_q <= bin_d;
      row_q <= row_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apsd_queue.sv =====
// two-entry job queue between the front and the back
// depends on apsd_pkg
`timescale 1ns / 1ps
`default_nettype none

module apsd_queue import apsd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire apsd_job_t data_i,
  output      logic      full_o,
  input  wire logic      pop_i,
  output      apsd_job_t data_o,
  output      logic      empty_o
);

  apsd_job_t  ent_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = ent_q[rd_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apsd_div.sv =====
// unsigned restoring divider, one quotient bit per cycle
// standalone, no package dependency
`timescale 1ns / 1ps
`default_nettype none

module apsd_div #(
  parameter int DVD_W = 45,
  parameter int DSR_W = 20
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DSR_W-1:0] divisor_i,
  output      logic             done_o,
  output      logic [DVD_W-1:0] quotient_o
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DSR_W:0]   r_sh, r_nx;
  logic             ge;

  assign r_sh = {rem_q, quo_q[DVD_W-1]};
  assign ge   = r_sh >= {1'b0, dsr_q};
  assign r_nx = ge ? (r_sh - {1'b0, dsr_q}) : r_sh;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= r_nx[DSR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/apsd_back.sv =====
// back end: bin store, per-bin sum sweep and peak search, reference and amplitude math
// depends on apsd_pkg and apsd_div
`timescale 1ns / 1ps
`default_nettype none

module apsd_back import apsd_pkg::*; #(
  parameter int MAX_BINS = 1024,
  parameter int MAX_AVG  = 16,
  localparam int NB_W = $clog2(MAX_BINS + 1),
  localparam int NA_W = $clog2(MAX_AVG + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [NB_W-1:0] nb_i,
  input  wire logic [NA_W-1:0] na_i,
  input  wire logic            mode_i,
  input  wire logic            q_empty_i,
  input  wire apsd_job_t       q_data_i,
  output      logic            q_pop_o,
  output      logic            clearing_o,
  input  wire logic            pop_i,
  output      logic            empty_o,
  output      apsd_out_t       out_data_o
);

  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int ROW_W  = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
  localparam int AW     = ROW_W + BIN_W;
  localparam int DEPTH  = 1 << AW;
  localparam int PSUM_W = 16 + $clog2(MAX_AVG);
  localparam int DVD_W  = 40 + NA_W;
  localparam int SQ_N   = (DVD_W + 1) / 2;
  localparam int SQC_W  = $clog2(SQ_N + 1);

  apsd_state_e state_q, state_d;

  // bin store: power in the upper half, frequency in the lower half
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rd_q;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [31:0]   wd;
  logic [AW-1:0] clr_q;

  // sweep position and read tags
  logic [BIN_W-1:0] sj_q, rd_j_q, peak_q;
  logic [ROW_W-1:0] sk_q, cur_row_q;
  logic             rdv_q, rd_first_q, rd_lastk_q;
  logic             sk_last, sj_last;

  logic        [PSUM_W-1:0] accp_q, ps_new, peak_sum_q;
  logic signed [PSUM_W-1:0] accf_q, fs_new, peak_fsum_q;
  logic        [PSUM_W-1:0] fabs;
  logic                     peak_take;

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [PSUM_W-1:0] div_dsr;
  logic [15+NA_W:0] prod;

  logic [2*SQ_N-1:0] sq_x_q;
  logic [SQ_N+1:0]   sq_rem_q, sq_sh, sq_trial, sq_rem_nx;
  logic [SQ_N-1:0]   sq_root_q;
  logic [SQC_W-1:0]  sq_cnt_q;
  logic              sq_ge;

  logic signed [15:0] ref_q, fcur, mag16, amp;
  logic [14:0]        mag;
  logic               res_load, res_valid_q;
  apsd_out_t          res_q;

  assign sk_last = (32'(sk_q) + 32'd1) >= 32'(na_i);
  assign sj_last = (32'(sj_q) + 32'd1) >= 32'(nb_i);

  assign ps_new    = (rd_first_q ? '0 : accp_q) + PSUM_W'(rd_q[31:16]);
  assign fs_new    = (rd_first_q ? '0 : accf_q) + PSUM_W'($signed(rd_q[15:0]));
  assign peak_take = rdv_q && rd_lastk_q && ((rd_j_q == '0) || (ps_new > peak_sum_q));
  assign fabs      = peak_fsum_q[PSUM_W-1] ? -peak_fsum_q : peak_fsum_q;
  assign prod      = (16 + NA_W)'(rd_q[31:16]) * (16 + NA_W)'(na_i);

  assign sq_sh     = {sq_rem_q[SQ_N-1:0], sq_x_q[2*SQ_N-1 -: 2]};
  assign sq_trial  = {sq_root_q, 2'b01};
  assign sq_ge     = sq_sh >= sq_trial;
  assign sq_rem_nx = sq_ge ? (sq_sh - sq_trial) : sq_sh;

  assign mag   = (sq_root_q > SQ_N'(32767)) ? 15'h7fff : sq_root_q[14:0];
  assign mag16 = $signed({1'b0, mag});
  assign fcur  = $signed(rd_q[15:0]);
  assign amp   = (fcur < ref_q) ? -mag16 : mag16;

  assign clearing_o = state_q == ST_CLEAR;
  assign empty_o    = ~res_valid_q;
  assign out_data_o = res_q;

  apsd_div #(
    .DVD_W(DVD_W),
    .DSR_W(PSUM_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dsr),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    state_d   = state_q;
    we        = 1'b0;
    wa        = clr_q;
    wd        = '0;
    re        = 1'b0;
    ra        = {sk_q, sj_q};
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dsr   = '0;
    res_load  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          we      = 1'b1;
          wa      = {q_data_i.row[ROW_W-1:0], q_data_i.bin[BIN_W-1:0]};
          wd      = {q_data_i.power, q_data_i.freq};
          if (q_data_i.last) state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        re = 1'b1;
        if (sk_last && sj_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_READP;
      end
      ST_READP: begin
        re      = 1'b1;
        ra      = {cur_row_q, peak_q};
        state_d = ST_REF;
      end
      ST_REF: begin
        if (mode_i) begin
          div_start = 1'b1;
          div_dvd   = DVD_W'(fabs);
          div_dsr   = PSUM_W'(na_i);
          state_d   = ST_DIVREF;
        end else begin
          state_d = ST_AMP;
        end
      end
      ST_DIVREF: begin
        if (div_done) state_d = ST_AMP;
      end
      ST_AMP: begin
        if (peak_sum_q == '0) begin
          state_d = ST_FINISH;
        end else begin
          div_start = 1'b1;
          div_dvd   = {prod, 24'd0};
          div_dsr   = peak_sum_q;
          state_d   = ST_DIVAMP;
        end
      end
      ST_DIVAMP: begin
        if (div_done) state_d = ST_SQRT;
      end
      ST_SQRT: begin
        if (sq_cnt_q == SQC_W'(1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (!res_valid_q || pop_i) begin
          res_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && q_pop_o && q_data_i.last) begin
      sj_q      <= '0;
      sk_q      <= '0;
      cur_row_q <= q_data_i.row[ROW_W-1:0];
    end else if (state_q == ST_SWEEP) begin
      if (sk_last) begin
        sk_q <= '0;
        sj_q <= sj_q + BIN_W'(1);
      end else begin
        sk_q <= sk_q + ROW_W'(1);
      end
    end
    rd_first_q <= sk_q == '0;
    rd_lastk_q <= sk_last;
    rd_j_q     <= sj_q;
    if (rdv_q) begin
      accp_q <= ps_new;
      accf_q <= fs_new;
    end
    if (peak_take) begin
      peak_q      <= rd_j_q;
      peak_sum_q  <= ps_new;
      peak_fsum_q <= fs_new;
    end
    if (state_q == ST_REF && !mode_i) begin
      ref_q <= '0;
    end else if (state_q == ST_DIVREF && div_done) begin
      ref_q <= peak_fsum_q[PSUM_W-1] ? -$signed(div_quo[15:0]) : $signed(div_quo[15:0]);
    end
    if (state_q == ST_AMP) begin
      sq_root_q <= '0;
    end else if (state_q == ST_DIVAMP && div_done) begin
      sq_x_q    <= (2 * SQ_N)'(div_quo);
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= SQC_W'(SQ_N);
    end else if (state_q == ST_SQRT) begin
      sq_x_q    <= {sq_x_q[2*SQ_N-3:0], 2'b00};
      sq_rem_q  <= sq_rem_nx;
      sq_root_q <= {sq_root_q[SQ_N-2:0], sq_ge};
      sq_cnt_q  <= sq_cnt_q - SQC_W'(1);
    end
    if (res_load) begin
      res_q.amplitude      <= amp;
      res_q.freq_reference <= ref_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      rdv_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + AW'(1);
      rdv_q <= state_q == ST_SWEEP;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
